// File: design/klb_pkg.sv
// ----------------------------------------------------------------------------
// klb_pkg
// Shared types and codes for the Kernighan-Lin bisection block.
// ----------------------------------------------------------------------------
package klb_pkg;

  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_SIDE  = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNBAL = 2'd1;
  localparam logic [1:0] ST_BAD   = 2'd2;

  localparam logic [14:0] SAT15 = 15'h7fff;

  typedef struct packed {
    logic [1:0] opcode;
    logic [5:0] vertex_u;
    logic [5:0] vertex_v;
    logic [3:0] weight;
    logic       side;
  } in_t;

  typedef struct packed {
    logic [5:0]  vertex_id;
    logic        vertex_side;
    logic [14:0] cut_size;
    logic [14:0] total_gain;
    logic [14:0] pass_count;
    logic [1:0]  status;
    logic        last;
  } out_t;

  typedef logic [6:0] cfg_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_LOAD, CMD_CLR, CMD_WUV, CMD_WVU, CMD_SIDE, CMD_ACK,
    CMD_CNT, CMD_CUT_RD, CMD_CUT_USE, CMD_UNBAL, CMD_D_RD, CMD_D_USE,
    CMD_S_RD, CMD_S_USE, CMD_STEP, CMD_U_A, CMD_U_B, CMD_U_C, CMD_APPLY,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       bad_edge;
    logic       bad_side;
    logic       clr_end;
    logic       i_end;
    logic       ij_end;
    logic       unbal;
    logic       k_over;
    logic       bestk_zero;
    logic       apply_end;
  } sts_t;

endpackage

// File: design/klb_ram.sv
// ----------------------------------------------------------------------------
// klb_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module klb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/klb_ctrl.sv
// ----------------------------------------------------------------------------
// klb_ctrl
// Sequencer: decodes items and steps the datapath through each pass.
// ----------------------------------------------------------------------------
module klb_ctrl
  import klb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [21:0] {
    S_CLR     = 22'h000001,
    S_IDLE    = 22'h000002,
    S_DEC     = 22'h000004,
    S_WUV     = 22'h000008,
    S_WVU     = 22'h000010,
    S_SIDE    = 22'h000020,
    S_ACK     = 22'h000040,
    S_CNT     = 22'h000080,
    S_CHK     = 22'h000100,
    S_CUT_RD  = 22'h000200,
    S_CUT_USE = 22'h000400,
    S_UNBAL   = 22'h000800,
    S_D_RD    = 22'h001000,
    S_D_USE   = 22'h002000,
    S_S_RD    = 22'h004000,
    S_S_USE   = 22'h008000,
    S_STEP    = 22'h010000,
    S_U_A     = 22'h020000,
    S_U_B     = 22'h040000,
    S_U_C     = 22'h080000,
    S_APPLY   = 22'h100000,
    S_EMIT    = 22'h200000
  } state_t;

  state_t state_r, state_nxt;
  logic   clr_ack_r, clr_ack_nxt;
  logic   unbal_r, unbal_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_ack_r <= 1'b0;
      unbal_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_ack_r <= clr_ack_nxt;
      unbal_r   <= unbal_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_ack_nxt = clr_ack_r;
    unbal_nxt   = unbal_r;
    cmd         = CMD_NONE;
    unique case (state_r)
      S_CLR: begin
        cmd = CMD_CLR;
        if (sts.clr_end) state_nxt = clr_ack_r ? S_ACK : S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts.op)
          OP_EDGE: state_nxt = sts.bad_edge ? S_ACK : S_WUV;
          OP_SIDE: state_nxt = sts.bad_side ? S_ACK : S_SIDE;
          OP_RUN:  state_nxt = S_CNT;
          default: begin
            clr_ack_nxt = 1'b1;
            state_nxt   = S_CLR;
          end
        endcase
      end
      S_WUV: begin
        cmd       = CMD_WUV;
        state_nxt = S_WVU;
      end
      S_WVU: begin
        cmd       = CMD_WVU;
        state_nxt = S_ACK;
      end
      S_SIDE: begin
        cmd       = CMD_SIDE;
        state_nxt = S_ACK;
      end
      S_ACK: begin
        cmd       = CMD_ACK;
        state_nxt = S_IDLE;
      end
      S_CNT: begin
        cmd = CMD_CNT;
        if (sts.i_end) state_nxt = S_CHK;
      end
      S_CHK: begin
        unbal_nxt = sts.unbal;
        state_nxt = sts.unbal ? S_CUT_RD : S_D_RD;
      end
      S_CUT_RD: begin
        cmd       = CMD_CUT_RD;
        state_nxt = S_CUT_USE;
      end
      S_CUT_USE: begin
        cmd = CMD_CUT_USE;
        if (sts.ij_end) state_nxt = unbal_r ? S_UNBAL : S_EMIT;
        else state_nxt = S_CUT_RD;
      end
      S_UNBAL: begin
        cmd       = CMD_UNBAL;
        state_nxt = S_IDLE;
      end
      S_D_RD: begin
        cmd       = CMD_D_RD;
        state_nxt = S_D_USE;
      end
      S_D_USE: begin
        cmd       = CMD_D_USE;
        state_nxt = sts.ij_end ? S_S_RD : S_D_RD;
      end
      S_S_RD: begin
        cmd       = CMD_S_RD;
        state_nxt = S_S_USE;
      end
      S_S_USE: begin
        cmd       = CMD_S_USE;
        state_nxt = sts.ij_end ? S_STEP : S_S_RD;
      end
      S_STEP: begin
        cmd       = CMD_STEP;
        state_nxt = S_U_A;
      end
      S_U_A: begin
        cmd       = CMD_U_A;
        state_nxt = S_U_B;
      end
      S_U_B: begin
        cmd       = CMD_U_B;
        state_nxt = S_U_C;
      end
      S_U_C: begin
        cmd = CMD_U_C;
        if (!sts.i_end) state_nxt = S_U_A;
        else if (!sts.k_over) state_nxt = S_S_RD;
        else if (sts.bestk_zero) state_nxt = S_CUT_RD;
        else state_nxt = S_APPLY;
      end
      S_APPLY: begin
        cmd = CMD_APPLY;
        if (sts.apply_end) state_nxt = S_D_RD;
      end
      S_EMIT: begin
        cmd = CMD_EMIT;
        if (sts.i_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: design/klb_dp.sv
// ----------------------------------------------------------------------------
// klb_dp
// Datapath: edge store, sides, locks, D values, pair search and totals.
// ----------------------------------------------------------------------------
module klb_dp
  import klb_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  input  in_t  in_data,
  input  logic cfg_we,
  input  cfg_t cfg_data,
  output sts_t sts,
  output logic out_valid,
  output out_t out_data
);

  localparam int IDXW   = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW     = $clog2(MAX_VERTICES + 1);
  localparam int CW     = (NW > 7) ? NW : 7;
  localparam int AW     = 2 * IDXW;
  localparam int DEPTH  = 1 << AW;
  localparam int DDEPTH = 1 << IDXW;
  localparam int DW     = IDXW + WEIGHT_BITS + 2;
  localparam int GW     = DW + 2;
  localparam int PW     = GW + IDXW;
  localparam int CTW0   = 2 * IDXW + WEIGHT_BITS;
  localparam int CTW    = (CTW0 > 16) ? CTW0 : 16;
  localparam int HD     = (MAX_VERTICES / 2 > 1) ? MAX_VERTICES / 2 : 1;
  localparam int HIW    = (HD > 1) ? $clog2(HD) : 1;

  cfg_t                    vc_r;
  in_t                     item_r;
  logic [NW-1:0]           n_r, half_r, k_r, bestk_r;
  logic [IDXW-1:0]         i_r, j_r, ba_r, bb_r;
  logic [AW-1:0]           ck_r;
  logic [NW-1:0]           acount_r;
  logic                    side_r [MAX_VERTICES];
  logic                    lock_r [MAX_VERTICES];
  logic signed [DW-1:0]    acc_r, wa_r;
  logic                    found_r;
  logic signed [GW-1:0]    best_r;
  logic signed [PW-1:0]    pre_r, bpre_r;
  logic [IDXW-1:0]         pa_r [HD];
  logic [IDXW-1:0]         pb_r [HD];
  logic [CTW-1:0]          cut_r, total_r;
  logic [14:0]             passes_r;

  logic [IDXW-1:0]         u_i, v_i;
  logic [NW-1:0]           n_sat;
  logic [CW-1:0]           vc_ext;
  logic                    i_end, j_end;
  logic                    ram_we;
  logic [AW-1:0]           waddr, raddr;
  logic [WEIGHT_BITS-1:0]  wdata, rdata;
  logic                    d_we;
  logic [IDXW-1:0]         d_waddr;
  logic signed [DW-1:0]    w_d, d_rdi, d_rdj, d_wdata, contrib, acc_nxt, delta;
  logic signed [GW-1:0]    g_c, best_v;
  logic signed [PW-1:0]    pre_nxt;
  logic                    elig;
  logic [HIW-1:0]          kidx, jidx;
  logic [1:0]              ack_status;

  klb_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_edges (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // D values: two copies, one read at row i, one at column j
  klb_ram #(.WIDTH(DW), .DEPTH(DDEPTH)) u_gain_i (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (i_r),
    .rdata (d_rdi)
  );

  klb_ram #(.WIDTH(DW), .DEPTH(DDEPTH)) u_gain_j (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (j_r),
    .rdata (d_rdj)
  );

  assign u_i    = IDXW'(item_r.vertex_u);
  assign v_i    = IDXW'(item_r.vertex_v);
  assign vc_ext = CW'(vc_r);
  assign n_sat  = (vc_ext < CW'(2)) ? NW'(2) :
                  (vc_ext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vc_r);
  assign i_end  = (NW'(i_r) == n_r - NW'(1));
  assign j_end  = (NW'(j_r) == n_r - NW'(1));
  assign kidx   = HIW'(k_r - NW'(1));
  assign jidx   = HIW'(j_r);

  always_comb begin
    sts.op         = item_r.opcode;
    sts.bad_edge   = (CW'(item_r.vertex_u) >= CW'(n_r)) ||
                     (CW'(item_r.vertex_v) >= CW'(n_r)) ||
                     (item_r.vertex_u == item_r.vertex_v);
    sts.bad_side   = (CW'(item_r.vertex_u) >= CW'(n_r));
    sts.clr_end    = &ck_r;
    sts.i_end      = i_end;
    sts.ij_end     = i_end && j_end;
    sts.unbal      = (acount_r != half_r);
    sts.k_over     = (k_r > half_r);
    sts.bestk_zero = (bestk_r == '0);
    sts.apply_end  = (NW'(j_r) + NW'(1) == bestk_r);
  end

  always_comb begin
    ram_we = 1'b0;
    waddr  = ck_r;
    wdata  = '0;
    raddr  = {i_r, j_r};
    unique case (cmd)
      CMD_CLR: ram_we = 1'b1;
      CMD_WUV: begin
        ram_we = 1'b1;
        waddr  = {u_i, v_i};
        wdata  = WEIGHT_BITS'(item_r.weight);
      end
      CMD_WVU: begin
        ram_we = 1'b1;
        waddr  = {v_i, u_i};
        wdata  = WEIGHT_BITS'(item_r.weight);
      end
      CMD_U_A: raddr = {i_r, ba_r};
      CMD_U_B: raddr = {i_r, bb_r};
      default: raddr = {i_r, j_r};
    endcase
  end

  assign w_d = DW'(rdata);

  always_comb begin
    if (j_r == i_r) contrib = '0;
    else if (side_r[i_r] != side_r[j_r]) contrib = w_d;
    else contrib = -w_d;
    acc_nxt = ((j_r == '0) ? DW'(0) : acc_r) + contrib;
    if (!side_r[i_r]) delta = (wa_r - w_d) <<< 1;
    else delta = (w_d - wa_r) <<< 1;
    g_c     = GW'(d_rdi) + GW'(d_rdj) - (GW'(w_d) <<< 1);
    elig    = !side_r[i_r] && !lock_r[i_r] && side_r[j_r] && !lock_r[j_r];
    best_v  = found_r ? best_r : GW'(0);
    pre_nxt = pre_r + PW'(best_v);
  end

  always_comb begin
    d_we    = 1'b0;
    d_waddr = i_r;
    d_wdata = acc_nxt;
    if (cmd == CMD_D_USE && j_end) d_we = 1'b1;
    if (cmd == CMD_U_C) begin
      d_we    = !lock_r[i_r];
      d_wdata = d_rdi + delta;
    end
  end

  always_comb begin
    unique case (item_r.opcode)
      OP_EDGE: ack_status = sts.bad_edge ? ST_BAD : ST_OK;
      OP_SIDE: ack_status = sts.bad_side ? ST_BAD : ST_OK;
      default: ack_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= cfg_t'(64);
      ck_r <= '0;
      for (int x = 0; x < MAX_VERTICES; x++) begin
        side_r[x] <= 1'b0;
        lock_r[x] <= 1'b0;
      end
    end else begin
      if (cfg_we) vc_r <= cfg_data;
      unique case (cmd)
        CMD_LOAD: begin
          item_r   <= in_data;
          n_r      <= n_sat;
          half_r   <= n_sat >> 1;
          i_r      <= '0;
          j_r      <= '0;
          acount_r <= '0;
          cut_r    <= '0;
          total_r  <= '0;
          passes_r <= '0;
        end
        CMD_CLR: ck_r <= ck_r + AW'(1);
        CMD_SIDE: side_r[u_i] <= item_r.side;
        CMD_CNT: begin
          if (!side_r[i_r]) acount_r <= acount_r + NW'(1);
          i_r <= i_end ? '0 : i_r + IDXW'(1);
        end
        CMD_CUT_USE: begin
          if (j_r > i_r && side_r[i_r] != side_r[j_r]) cut_r <= cut_r + CTW'(rdata);
          j_r <= j_end ? '0 : j_r + IDXW'(1);
          if (j_end) i_r <= i_end ? '0 : i_r + IDXW'(1);
        end
        CMD_D_USE: begin
          acc_r <= acc_nxt;
          if (j_end) lock_r[i_r] <= 1'b0;
          if (i_end && j_end) begin
            pre_r   <= '0;
            bpre_r  <= '0;
            bestk_r <= '0;
            k_r     <= NW'(1);
            found_r <= 1'b0;
            ba_r    <= '0;
            bb_r    <= '0;
          end
          j_r <= j_end ? '0 : j_r + IDXW'(1);
          if (j_end) i_r <= i_end ? '0 : i_r + IDXW'(1);
        end
        CMD_S_USE: begin
          if (elig && (!found_r || g_c > best_r)) begin
            found_r <= 1'b1;
            best_r  <= g_c;
            ba_r    <= i_r;
            bb_r    <= j_r;
          end
          j_r <= j_end ? '0 : j_r + IDXW'(1);
          if (j_end) i_r <= i_end ? '0 : i_r + IDXW'(1);
        end
        CMD_STEP: begin
          lock_r[ba_r] <= 1'b1;
          lock_r[bb_r] <= 1'b1;
          pa_r[kidx]   <= ba_r;
          pb_r[kidx]   <= bb_r;
          pre_r        <= pre_nxt;
          if (pre_nxt > bpre_r) begin
            bpre_r  <= pre_nxt;
            bestk_r <= k_r;
          end
          k_r <= k_r + NW'(1);
        end
        CMD_U_B: wa_r <= w_d;
        CMD_U_C: begin
          if (i_end) begin
            found_r <= 1'b0;
            ba_r    <= '0;
            bb_r    <= '0;
          end
          i_r <= i_end ? '0 : i_r + IDXW'(1);
        end
        CMD_APPLY: begin
          side_r[pa_r[jidx]] <= 1'b1;
          side_r[pb_r[jidx]] <= 1'b0;
          if (sts.apply_end) begin
            j_r      <= '0;
            total_r  <= total_r + CTW'(bpre_r);
            passes_r <= (passes_r == SAT15) ? passes_r : passes_r + 15'd1;
          end else begin
            j_r <= j_r + IDXW'(1);
          end
        end
        CMD_EMIT: i_r <= i_end ? '0 : i_r + IDXW'(1);
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid = 1'b0;
    out_data  = '0;
    unique case (cmd)
      CMD_ACK: begin
        out_valid       = 1'b1;
        out_data.status = ack_status;
        out_data.last   = 1'b1;
      end
      CMD_UNBAL: begin
        out_valid         = 1'b1;
        out_data.cut_size = (cut_r > CTW'(SAT15)) ? SAT15 : 15'(cut_r);
        out_data.status   = ST_UNBAL;
        out_data.last     = 1'b1;
      end
      CMD_EMIT: begin
        out_valid            = 1'b1;
        out_data.vertex_id   = 6'(i_r);
        out_data.vertex_side = side_r[i_r];
        out_data.cut_size    = (cut_r > CTW'(SAT15)) ? SAT15 : 15'(cut_r);
        out_data.total_gain  = (total_r > CTW'(SAT15)) ? SAT15 : 15'(total_r);
        out_data.pass_count  = passes_r;
        out_data.status      = ST_OK;
        out_data.last        = i_end;
      end
      default: ;
    endcase
  end

endmodule

// File: design/kernighan_lin_bisection_top.sv
// ----------------------------------------------------------------------------
// kernighan_lin_bisection_top
// Weighted graph bisection by repeated Kernighan-Lin passes.
// ----------------------------------------------------------------------------
// Edge write: decode, write (u,v), write (v,u), ack; side write: decode, write, ack;
// bad item: decode, ack. Clear: one edge-store word per cycle, then the ack.
// Run: decode, count side A; if unbalanced, the cut and one word; else per pass
// D values, n/2 searches with D updates, applied swaps; then cut and n results.
// Edge-store port (one read a cycle) sets the pace; one item at a time.
// Reset starts a clear of the edge store (busy high, no ack) and sets sides to A.
module kernighan_lin_bisection_top
  import klb_pkg::*;
#(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  cfg_t cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  klb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  klb_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result while idle");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last |=> !out_valid)
    else $error("result after last");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_valid)
    else $error("accept not followed by busy");

endmodule

// File: tb/sv/kl_checker.sv
// ----------------------------------------------------------------------------
// kl_checker
// Watches the command, result and config channels of the bisection block,
// keeps its own graph model, predicts every result word and compares them.
// ----------------------------------------------------------------------------
module kl_checker
  import klb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  cfg_t cfg_data,
  output int   fails,
  output int   pending,
  output int   runs_done
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 64;

  logic [3:0] wmat [NV][NV];
  bit         part [NV];
  bit         locked [NV];
  int         dval [NV];
  int         pre [NV/2+1];
  int         swap_a [NV/2+1];
  int         swap_b [NV/2+1];
  cfg_t       vcount;
  out_t       expected_words [$];

  function automatic int n_used();
    if (vcount < 2) return 2;
    if (vcount > NV) return NV;
    return int'(vcount);
  endfunction

  function automatic int cut_weight(int n);
    int s;
    s = 0;
    for (int x = 0; x < n; x++)
      for (int y = x + 1; y < n; y++)
        if (part[x] != part[y]) s += wmat[x][y];
    return s;
  endfunction

  function automatic logic [14:0] sat15(longint v);
    return (v > 32767) ? SAT15 : v[14:0];
  endfunction

  function automatic void push_word(int id, bit sd, longint cut, longint gain,
                                    longint passes, logic [1:0] st, bit lst);
    out_t o;
    o.vertex_id   = id[5:0];
    o.vertex_side = sd;
    o.cut_size    = sat15(cut);
    o.total_gain  = sat15(gain);
    o.pass_count  = sat15(passes);
    o.status      = st;
    o.last        = lst;
    expected_words.push_back(o);
  endfunction

  function automatic int kl_pass(int n);
    int half, bestk, best, ba, bb, g, d;
    bit found;
    half  = n / 2;
    bestk = 0;
    for (int x = 0; x < n; x++) begin
      d = 0;
      for (int y = 0; y < n; y++) begin
        if (y == x) continue;
        if (part[x] != part[y]) d += wmat[x][y];
        else d -= wmat[x][y];
      end
      dval[x] = d;
      locked[x] = 0;
    end
    pre[0] = 0;
    for (int k = 1; k <= half; k++) begin
      found = 0; best = 0; ba = 0; bb = 0;
      for (int x = 0; x < n; x++) begin
        if (part[x] || locked[x]) continue;
        for (int y = 0; y < n; y++) begin
          if (!part[y] || locked[y]) continue;
          g = dval[x] + dval[y] - 2 * wmat[x][y];
          if (!found || g > best) begin
            found = 1; best = g; ba = x; bb = y;
          end
        end
      end
      if (!found) best = 0;
      locked[ba] = 1;
      locked[bb] = 1;
      swap_a[k] = ba;
      swap_b[k] = bb;
      for (int x = 0; x < n; x++) begin
        if (locked[x]) continue;
        if (!part[x]) dval[x] += 2 * wmat[x][ba] - 2 * wmat[x][bb];
        else dval[x] += 2 * wmat[x][bb] - 2 * wmat[x][ba];
      end
      pre[k] = pre[k-1] + best;
      if (pre[k] > pre[bestk]) bestk = k;
    end
    if (bestk == 0) return 0;
    for (int k = 1; k <= bestk; k++) begin
      part[swap_a[k]] = 1;
      part[swap_b[k]] = 0;
    end
    return pre[bestk];
  endfunction

  function automatic void predict_item(in_t it);
    int n, acount, g, c;
    longint total, passes;
    n = n_used();
    case (it.opcode)
      OP_EDGE: begin
        if (it.vertex_u >= n || it.vertex_v >= n || it.vertex_u == it.vertex_v) begin
          push_word(0, 0, 0, 0, 0, ST_BAD, 1);
        end else begin
          wmat[it.vertex_u][it.vertex_v] = it.weight;
          wmat[it.vertex_v][it.vertex_u] = it.weight;
          push_word(0, 0, 0, 0, 0, ST_OK, 1);
        end
      end
      OP_SIDE: begin
        if (it.vertex_u >= n) begin
          push_word(0, 0, 0, 0, 0, ST_BAD, 1);
        end else begin
          part[it.vertex_u] = it.side;
          push_word(0, 0, 0, 0, 0, ST_OK, 1);
        end
      end
      OP_CLEAR: begin
        foreach (wmat[x, y]) wmat[x][y] = '0;
        push_word(0, 0, 0, 0, 0, ST_OK, 1);
      end
      default: begin
        acount = 0;
        for (int x = 0; x < n; x++) if (!part[x]) acount++;
        if (acount != n / 2) begin
          push_word(0, 0, cut_weight(n), 0, 0, ST_UNBAL, 1);
        end else begin
          total = 0; passes = 0;
          forever begin
            g = kl_pass(n);
            if (g <= 0) break;
            total += g;
            passes++;
          end
          c = cut_weight(n);
          for (int x = 0; x < n; x++)
            push_word(x, part[x], c, total, passes, ST_OK, x == n - 1);
          runs_done++;
        end
      end
    endcase
  endfunction

  initial begin
    fails = 0;
    pending = 0;
    runs_done = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      foreach (wmat[x, y]) wmat[x][y] = '0;
      foreach (part[x]) begin
        part[x] = 0;
        locked[x] = 0;
      end
      vcount = 7'd64;
      expected_words.delete();
    end else begin
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_data);
          fails++;
        end else begin
          want = expected_words.pop_front();
          if (out_data.vertex_id !== want.vertex_id ||
              out_data.vertex_side !== want.vertex_side ||
              out_data.cut_size !== want.cut_size ||
              out_data.total_gain !== want.total_gain ||
              out_data.pass_count !== want.pass_count ||
              out_data.status !== want.status ||
              out_data.last !== want.last) begin
            $display("%0t: result mismatch expected %p actual %p", $time, want, out_data);
            fails++;
          end
        end
      end
      if (start && !busy) predict_item(in_data);
      if (cfg_valid && cfg_ready) vcount = cfg_data;
    end
    pending = expected_words.size();
  end

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives loads, clears and partition runs into the bisection block under
// several sender gap rates and vertex counts; kl_checker scores the results.
// ----------------------------------------------------------------------------
module testbench
  import klb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  cfg_t cfg_data = '0;
  int   fails, pending, runs_done;
  int   gap_pct = 0;
  int   items_sent = 0;
  int   cfg_writes = 0;

  always #4 clk = ~clk;

  kernighan_lin_bisection_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  kl_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data), .fails(fails),
    .pending(pending), .runs_done(runs_done)
  );

  task automatic send_word(logic [1:0] op, int u, int v, int w, bit sd);
    in_t it;
    it.opcode = op;
    it.vertex_u = u[5:0];
    it.vertex_v = v[5:0];
    it.weight = w[3:0];
    it.side = sd;
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk);
      start <= 0;
      in_data <= in_t'($urandom);
    end
    @(negedge clk);
    start <= 1;
    in_data <= it;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic quiesce();
    @(negedge clk);
    start <= 0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(int value);
    quiesce();
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= value[6:0];
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 0;
    cfg_writes++;
  endtask

  // optional clear, balanced random sides over vertices 0..n-1, then mostly random edges and a run
  task automatic graph_round(int n, int edges, bit do_clear);
    int perm [64];
    int j, t;
    for (int i = 0; i < n; i++) perm[i] = i;
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      t = perm[i]; perm[i] = perm[j]; perm[j] = t;
    end
    if (do_clear) send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
    for (int i = 0; i < n; i++)
      send_word(OP_SIDE, perm[i], $urandom, $urandom, i >= n / 2);
    for (int e = 0; e < edges; e++) begin
      if ($urandom_range(9) == 0)
        send_word($urandom_range(1) ? OP_EDGE : OP_SIDE, $urandom_range(63),
                  $urandom_range(63), $urandom_range(15), $urandom_range(1));
      else begin
        j = $urandom_range(n - 1);
        t = (j + 1 + $urandom_range(n - 2)) % n;
        send_word(OP_EDGE, j, t, $urandom_range(15), $urandom);
      end
    end
    send_word(OP_RUN, $urandom, $urandom, $urandom, $urandom);
  endtask

  initial begin
    int modes [3] = '{0, 85, 26};
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed
    set_count(4);
    send_word(OP_EDGE, 0, 1, 15, 1);
    send_word(OP_EDGE, 2, 2, 5, 0);
    send_word(OP_EDGE, 63, 0, 3, 0);
    send_word(OP_EDGE, 1, 63, 3, 0);
    send_word(OP_EDGE, 0, 3, 0, 0);
    send_word(OP_EDGE, 1, 2, 7, 0);
    send_word(OP_EDGE, 0, 2, 1, 0);
    send_word(OP_SIDE, 63, 0, 0, 1);
    send_word(OP_RUN, 0, 0, 0, 0);
    send_word(OP_SIDE, 1, 0, 0, 1);
    send_word(OP_SIDE, 2, 0, 0, 1);
    send_word(OP_RUN, 63, 63, 15, 1);
    send_word(OP_SIDE, 0, 0, 0, 1);
    send_word(OP_RUN, 0, 0, 0, 0);
    send_word(OP_CLEAR, 0, 0, 0, 0);
    send_word(OP_RUN, 0, 0, 0, 0);
    set_count(0);
    send_word(OP_SIDE, 1, 0, 0, 1);
    send_word(OP_SIDE, 0, 0, 0, 0);
    send_word(OP_EDGE, 0, 1, 9, 0);
    send_word(OP_RUN, 0, 0, 0, 0);
    set_count(127);
    send_word(OP_RUN, 0, 0, 0, 0);
    send_word(OP_EDGE, 63, 62, 6, 1);

    // random rounds over the gap rates
    for (int r = 0; r < 3; r++) begin
      gap_pct = modes[r % 3];
      n = $urandom_range(2, 8);
      set_count(n);
      graph_round(n, $urandom_range(n, 2 * n), $urandom_range(2) == 0);
    end

    // one full-size run with a sparse graph
    gap_pct = 0;
    set_count(64);
    graph_round(64, 3, 1);

    quiesce();
    repeat (50) @(posedge clk);
    $display("Sent %0d commands with %0d count writes, vertex counts 2 to 64,",
             items_sent, cfg_writes);
    $display("%0d balanced partition runs, gap rates 0/85/26 percent.", runs_done);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: kernighan_lin_bisection_top.f
design/klb_pkg.sv
design/klb_ram.sv
design/klb_ctrl.sv
design/klb_dp.sv
design/kernighan_lin_bisection_top.sv
tb/sv/kl_checker.sv
tb/sv/testbench.sv
